@@ src/osrm_pkg.sv @@
`timescale 1ns / 1ps
package osrm_pkg;

    localparam int DATA_W       = 32;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int POS_W        = 4;
    localparam int COUNT_W      = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    typedef enum logic {
        CMP_LESS,
        CMP_EQUAL
    } t_cmp_mode;

endpackage

@@ src/osrm_if.sv @@
`timescale 1ns / 1ps
interface osrm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [osrm_pkg::CMD_W-1:0]            cmd;
    logic signed [osrm_pkg::DATA_W-1:0]    value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface osrm_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [osrm_pkg::STATUS_W-1:0]         status;
    logic signed [osrm_pkg::DATA_W-1:0]    result_value;
    logic [osrm_pkg::POS_W-1:0]            position;
    logic [osrm_pkg::COUNT_W-1:0]          count;

    modport source (output valid, output status, output result_value, output position,
                    output count, input ready);
    modport sink   (input valid, input status, input result_value, input position,
                    input count, output ready);
endinterface

@@ src/osrm_ram.sv @@
`timescale 1ns / 1ps
module osrm_ram #(
    parameter int WIDTH = osrm_pkg::DATA_W,
    parameter int DEPTH = osrm_pkg::CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/osrm_cmp.sv @@
`timescale 1ns / 1ps
module osrm_cmp (
    input  osrm_pkg::t_cmp_mode                i_mode,
    input  logic signed [osrm_pkg::DATA_W-1:0] i_a,
    input  logic signed [osrm_pkg::DATA_W-1:0] i_b,
    output logic                               o_hit
);

    always_comb begin
        case (i_mode)
            osrm_pkg::CMP_LESS:  o_hit = (i_a < i_b);
            osrm_pkg::CMP_EQUAL: o_hit = (i_a == i_b);
            default:             o_hit = 1'b0;
        endcase
    end

endmodule

@@ src/ordered_store_remove_min.sv @@
`timescale 1ns / 1ps
// Ordered store of up to CAPACITY signed 32-bit values in a single-port-read RAM, one
// command at a time, one result per command. Append and the full/empty/unused-code
// cases go from the transfer straight to S_FINISH, which loads the output register.
// Search walks the entries from the head through one shared comparator, one entry a
// cycle, and stops at the first match. Remove-min scans all count entries, then moves
// each entry after the minimum down one place through the same read port. The input
// is not ready while a command is in progress; a finished result sits in an output
// register and the next command may be taken while it waits.
module ordered_store_remove_min #(
    parameter int CAPACITY = osrm_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    osrm_in_if.sink           i_req,
    osrm_out_if.source        o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    osrm_pkg::t_state r_state, n_state;

    logic [CW-1:0]                        r_count, n_count;
    logic [CW-1:0]                        r_idx, n_idx;
    logic                                 r_pend, n_pend;
    logic [AW-1:0]                        r_pend_idx, n_pend_idx;
    logic [osrm_pkg::CMD_W-1:0]           r_cmd, n_cmd;
    logic signed [osrm_pkg::DATA_W-1:0]   r_key, n_key;
    logic signed [osrm_pkg::DATA_W-1:0]   r_best_val, n_best_val;
    logic [AW-1:0]                        r_best_idx, n_best_idx;
    logic [osrm_pkg::STATUS_W-1:0]        r_status, n_status;
    logic signed [osrm_pkg::DATA_W-1:0]   r_res, n_res;
    logic [osrm_pkg::POS_W-1:0]           r_pos, n_pos;

    logic                                 r_out_valid, n_out_valid;
    logic [osrm_pkg::STATUS_W-1:0]        r_o_status, n_o_status;
    logic signed [osrm_pkg::DATA_W-1:0]   r_o_res, n_o_res;
    logic [osrm_pkg::POS_W-1:0]           r_o_pos, n_o_pos;
    logic [osrm_pkg::COUNT_W-1:0]         r_o_count, n_o_count;

    logic                                 mem_we;
    logic [AW-1:0]                        mem_waddr;
    logic [osrm_pkg::DATA_W-1:0]          mem_wdata;
    logic [osrm_pkg::DATA_W-1:0]          mem_rdata;

    osrm_pkg::t_cmp_mode                  cmp_mode;
    logic signed [osrm_pkg::DATA_W-1:0]   cmp_b;
    logic                                 cmp_hit;

    logic                                 in_xfer;
    logic                                 issue;
    logic                                 walk_done;
    logic                                 search_hit;
    logic                                 out_free;

    osrm_ram #(
        .WIDTH (osrm_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    osrm_cmp u_cmp (
        .i_mode (cmp_mode),
        .i_a    (mem_rdata),
        .i_b    (cmp_b),
        .o_hit  (cmp_hit)
    );

    assign i_req.ready = (r_state == osrm_pkg::S_IDLE);
    assign in_xfer     = i_req.valid && i_req.ready;
    assign issue       = (r_idx < r_count);
    assign walk_done   = !issue && !r_pend;
    assign cmp_mode    = (r_cmd == osrm_pkg::CMD_SEARCH) ? osrm_pkg::CMP_EQUAL
                                                         : osrm_pkg::CMP_LESS;
    assign cmp_b       = (r_cmd == osrm_pkg::CMD_SEARCH) ? r_key : r_best_val;
    assign search_hit  = r_pend && cmp_hit && (r_cmd == osrm_pkg::CMD_SEARCH);
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.result_value = r_o_res;
    assign o_rsp.position     = r_o_pos;
    assign o_rsp.count        = r_o_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            osrm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if ((i_req.cmd inside {osrm_pkg::CMD_REMOVE, osrm_pkg::CMD_SEARCH})
                        && r_count != '0) begin
                        n_state = osrm_pkg::S_SCAN;
                    end else begin
                        n_state = osrm_pkg::S_FINISH;
                    end
                end
            end
            osrm_pkg::S_SCAN: begin
                if (search_hit) begin
                    n_state = osrm_pkg::S_FINISH;
                end else if (walk_done) begin
                    n_state = (r_cmd == osrm_pkg::CMD_REMOVE) ? osrm_pkg::S_SHIFT
                                                              : osrm_pkg::S_FINISH;
                end
            end
            osrm_pkg::S_SHIFT: begin
                if (walk_done) begin
                    n_state = osrm_pkg::S_FINISH;
                end
            end
            osrm_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = osrm_pkg::S_IDLE;
                end
            end
            default: n_state = osrm_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_idx  = r_idx[AW-1:0];
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_best_val  = r_best_val;
        n_best_idx  = r_best_idx;
        n_status    = r_status;
        n_res       = r_res;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_o_status  = r_o_status;
        n_o_res     = r_o_res;
        n_o_pos     = r_o_pos;
        n_o_count   = r_o_count;
        mem_we      = 1'b0;
        mem_waddr   = r_count[AW-1:0];
        mem_wdata   = i_req.value;

        case (r_state)
            osrm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_cmd    = i_req.cmd;
                    n_key    = i_req.value;
                    n_idx    = '0;
                    n_status = osrm_pkg::STAT_OK;
                    n_res    = '0;
                    n_pos    = '0;
                    case (i_req.cmd)
                        osrm_pkg::CMD_APPEND: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = osrm_pkg::STAT_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        osrm_pkg::CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = osrm_pkg::STAT_EMPTY;
                            end
                        end
                        osrm_pkg::CMD_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = osrm_pkg::STAT_MISS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            osrm_pkg::S_SCAN: begin
                if (issue) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + CW'(1);
                end
                if (r_pend && r_cmd == osrm_pkg::CMD_REMOVE
                    && (r_pend_idx == '0 || cmp_hit)) begin
                    n_best_val = mem_rdata;
                    n_best_idx = r_pend_idx;
                end
                if (search_hit) begin
                    n_pos  = osrm_pkg::POS_W'(r_pend_idx);
                    n_pend = 1'b0;
                end else if (walk_done) begin
                    if (r_cmd == osrm_pkg::CMD_REMOVE) begin
                        n_res = r_best_val;
                        n_idx = CW'(r_best_idx) + CW'(1);
                    end else begin
                        n_status = osrm_pkg::STAT_MISS;
                    end
                end
            end
            osrm_pkg::S_SHIFT: begin
                if (issue) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + CW'(1);
                end
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pend_idx - AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (walk_done) begin
                    n_count = r_count - CW'(1);
                end
            end
            osrm_pkg::S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_res     = r_res;
                    n_o_pos     = r_pos;
                    n_o_count   = osrm_pkg::COUNT_W'(r_count);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= osrm_pkg::S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_pend_idx <= n_pend_idx;
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_status   <= n_status;
        r_res      <= n_res;
        r_pos      <= n_pos;
        r_o_status <= n_o_status;
        r_o_res    <= n_o_res;
        r_o_pos    <= n_o_pos;
        r_o_count  <= n_o_count;
    end

endmodule
